/* rtl/largest_empty_square_finder_assert.svh */
// ---------------------------------------------------------------------------
// largest empty square finder assertion macros
// shared property forms for the block's internal checks
// ---------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH

// same-cycle implication under the async reset
`define LESF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lesf assertion failed");

// next-cycle implication under the async reset
`define LESF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lesf assertion failed");

`endif

/* rtl/lesf_pkg.sv */
// ---------------------------------------------------------------------------
// lesf_pkg
// widths, reset values, register indexes and the min3 helper of the largest empty square finder
// ---------------------------------------------------------------------------
package lesf_pkg;

	localparam int unsigned MAX_COLS_DEF = 1024;
	localparam int unsigned MAX_ROWS_DEF = 1024;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned COLS_W = 11;
	localparam int unsigned SIDE_W = 11;
	localparam int unsigned POS_W  = 10;

	localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd111;
	localparam logic [COLS_W-1:0] GRID_COLS_RST = 11'd1024;

	// configuration register indexes
	localparam logic REG_OBSTACLE  = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	function automatic logic [SIDE_W-1:0] min3(
		input logic [SIDE_W-1:0] a,
		input logic [SIDE_W-1:0] b,
		input logic [SIDE_W-1:0] c
	);
		logic [SIDE_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

endpackage

/* rtl/largest_empty_square_finder.sv */
// ---------------------------------------------------------------------------
// largest_empty_square_finder
// streaming largest all-empty square search over a row-major byte grid
// ---------------------------------------------------------------------------
// Takes one grid cell per clock, sustained, with no gaps needed between cells
// or between grids. Each cell is a read-modify-write of a single line store
// (MAX_COLS words holding the previous row's square sizes, registered read):
// the read is issued as the cell is accepted and the update is written back
// from the compute stage, with a bypass for the one-column grid where both
// hit the same word. The result register is loaded as the last cell leaves
// the compute stage. The line store needs no clearing pass; only the last
// cell of a grid can be held back, only while a previous result is stalled.
module largest_empty_square_finder #(
	parameter int unsigned MAX_COLS = lesf_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [lesf_pkg::COLS_W-1:0] cfg_data,
	// cell beats
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lesf_pkg::CHAR_W-1:0] cell_char,
	input  logic                       last_cell,
	// result beats
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [lesf_pkg::POS_W-1:0]  top_row,
	output logic [lesf_pkg::POS_W-1:0]  left_col,
	output logic [lesf_pkg::SIDE_W-1:0] side
);
	import lesf_pkg::*;

	`include "largest_empty_square_finder_assert.svh"

	localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned RW = $clog2(MAX_ROWS + 1);

	// configuration registers
	logic [CHAR_W-1:0] obstacle_q;
	logic [COLS_W-1:0] grid_cols_q;

	// front end scan position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// compute stage
	logic              valid_s1;
	logic              blocked_s1;
	logic              last_s1;
	logic              active_s1;
	logic              first_row_s1;
	logic              row_end_s1;
	logic              fwd_s1;
	logic [CW-1:0]     col_s1;
	logic [RW-1:0]     row_s1;
	logic [SIDE_W-1:0] up_mem_s1;

	// running state
	logic [SIDE_W-1:0] left_q;
	logic [SIDE_W-1:0] diag_q;
	logic [SIDE_W-1:0] last_cur_q;
	logic [SIDE_W-1:0] best_side_q;
	logic [POS_W-1:0]  best_row_q;
	logic [POS_W-1:0]  best_col_q;

	// result register
	logic              out_valid_q;
	logic              found_q;
	logic [POS_W-1:0]  top_row_q;
	logic [POS_W-1:0]  left_col_q;
	logic [SIDE_W-1:0] side_q;

	logic [SIDE_W-1:0] line_mem [MAX_COLS];

	logic              accept;
	logic              fire_s1;
	logic [31:0]       cols_w;
	logic              row_end;
	logic              active;
	logic              fwd;
	logic [SIDE_W-1:0] up;
	logic [SIDE_W-1:0] left;
	logic [SIDE_W-1:0] diag;
	logic [SIDE_W-1:0] cur;
	logic              better;
	logic [SIDE_W-1:0] nb_side;
	logic [POS_W-1:0]  nb_row;
	logic [POS_W-1:0]  nb_col;
	logic [RW+POS_W-1:0] row_ext;
	logic [CW+POS_W-1:0] col_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q  <= OBSTACLE_RST;
			grid_cols_q <= GRID_COLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OBSTACLE: begin
					obstacle_q <= cfg_data[CHAR_W-1:0];
				end
				REG_GRID_COLS: begin
					grid_cols_q <= cfg_data;
				end
			endcase
		end
	end

	// only a final cell can be held, and only behind an unread result
	assign fire_s1  = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cols_w = 32'(grid_cols_q);
		if (cols_w == 32'd0) begin
			cols_w = 32'd1;
		end else if (cols_w > 32'(MAX_COLS)) begin
			cols_w = 32'(MAX_COLS);
		end
	end

	assign row_end = (32'(col_q) + 32'd1) >= cols_w;
	assign active  = 32'(row_q) < 32'(MAX_ROWS);
	// write of the previous cell lands on the word being read now
	assign fwd     = fire_s1 && active_s1 && (col_s1 == col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_cell) begin
				col_q <= '0;
				row_q <= '0;
			end else if (active) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blocked_s1   <= (cell_char == obstacle_q);
			last_s1      <= last_cell;
			active_s1    <= active;
			first_row_s1 <= (row_q == '0);
			row_end_s1   <= row_end;
			fwd_s1       <= fwd;
			col_s1       <= col_q;
			row_s1       <= row_q;
		end
	end

	// line store: read port
	always_ff @(posedge clk) begin
		if (accept) begin
			up_mem_s1 <= line_mem[col_q];
		end
	end

	// line store: write port
	always_ff @(posedge clk) begin
		if (fire_s1 && active_s1) begin
			line_mem[col_s1] <= cur;
		end
	end

	always_comb begin
		if (first_row_s1) begin
			up = '0;
		end else if (fwd_s1) begin
			up = last_cur_q;
		end else begin
			up = up_mem_s1;
		end
		left = (col_s1 == '0) ? '0 : left_q;
		diag = (col_s1 == '0) ? '0 : diag_q;
		cur  = blocked_s1 ? '0 : min3(left, up, diag) + 1'b1;
	end

	assign row_ext = {{POS_W{1'b0}}, row_s1};
	assign col_ext = {{POS_W{1'b0}}, col_s1};
	assign better  = active_s1 && (cur > best_side_q);

	always_comb begin
		nb_side = best_side_q;
		nb_row  = best_row_q;
		nb_col  = best_col_q;
		if (better) begin
			nb_side = cur;
			nb_row  = row_ext[POS_W-1:0];
			nb_col  = col_ext[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				left_q      <= '0;
				diag_q      <= '0;
				best_side_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				if (active_s1) begin
					left_q <= row_end_s1 ? '0 : cur;
					diag_q <= row_end_s1 ? '0 : up;
				end
				best_side_q <= nb_side;
				best_row_q  <= nb_row;
				best_col_q  <= nb_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && active_s1) begin
			last_cur_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// corner is bottom-right minus side plus one, kept modulo the field width
	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			if (nb_side != '0) begin
				found_q    <= 1'b1;
				top_row_q  <= nb_row + 1'b1 - nb_side[POS_W-1:0];
				left_col_q <= nb_col + 1'b1 - nb_side[POS_W-1:0];
				side_q     <= nb_side;
			end else begin
				found_q    <= 1'b0;
				top_row_q  <= '0;
				left_col_q <= '0;
				side_q     <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign top_row   = top_row_q;
	assign left_col  = left_col_q;
	assign side      = side_q;

	`LESF_ASSERT_NEXT(a_fwd_has_item, clk, arst_n, accept && fwd, valid_s1 && fwd_s1)
	`LESF_ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, valid_s1 && last_s1 && out_valid_q)
	`LESF_ASSERT_NEXT(a_last_gives_result, clk, arst_n, fire_s1 && last_s1, out_valid_q)
	`LESF_ASSERT_IMPLY(a_empty_best_clear, clk, arst_n, best_side_q == '0, best_row_q == '0 && best_col_q == '0)

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the largest empty square finder. Grids of byte cells are
// streamed in, with random gaps on the cell side and random stalls on the
// result side. A predictor in this file tracks the square sizes row by row
// and queues the answer for each grid, which is checked field by field
// against every result beat. Directed grids cover the register extremes,
// ties, short grids, width clamping, row saturation and a width change
// mid-row. Random grids follow, most of them well formed.
// ---------------------------------------------------------------------------
module tb;
	import lesf_pkg::*;

	typedef struct {
		logic              found;
		logic [POS_W-1:0]  top_row;
		logic [POS_W-1:0]  left_col;
		logic [SIDE_W-1:0] side;
	} square_t;

	localparam int unsigned TB_CW = $clog2(MAX_COLS_DEF);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_OBSTACLE;
	logic [COLS_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CHAR_W-1:0] cell_char = '0;
	logic              last_cell = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [POS_W-1:0]  top_row;
	logic [POS_W-1:0]  left_col;
	logic [SIDE_W-1:0] side;

	// pacing of both sides, changed per grid
	int gap_max = 0;
	int stall_max = 0;
	int stall_left = 0;
	int mismatches = 0;

	// predictor state
	square_t           pending_squares[$];
	logic [SIDE_W-1:0] upper_sizes[MAX_COLS_DEF];
	logic [SIDE_W-1:0] run_left, run_diag, best_side;
	int unsigned       cur_col, cur_row, best_row_end, best_col_end;
	logic [CHAR_W-1:0] blocked_byte = OBSTACLE_RST;
	logic [COLS_W-1:0] row_width = GRID_COLS_RST;

	largest_empty_square_finder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_char (cell_char),
		.last_cell (last_cell),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.top_row   (top_row),
		.left_col  (left_col),
		.side      (side)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic void clear_search();
		run_left = '0;
		run_diag = '0;
		cur_col = 0;
		cur_row = 0;
		best_side = '0;
		best_row_end = 0;
		best_col_end = 0;
	endfunction

	// one accepted cell: min-of-three update, best square tracking, result on last
	function automatic void track_cell(input logic [CHAR_W-1:0] ch, input logic lc);
		int unsigned       cols, c;
		logic [SIDE_W-1:0] up, dg, lf, m, here;
		square_t           res;
		cols = (row_width == 0) ? 1 : ((row_width > MAX_COLS_DEF) ? MAX_COLS_DEF : row_width);
		if (cur_row < MAX_ROWS_DEF) begin
			c = (cur_col >= MAX_COLS_DEF) ? MAX_COLS_DEF - 1 : cur_col;
			up = (cur_row == 0) ? '0 : upper_sizes[c[TB_CW-1:0]];
			dg = (c == 0) ? '0 : run_diag;
			lf = (c == 0) ? '0 : run_left;
			m = (lf < up) ? lf : up;
			if (dg < m)
				m = dg;
			here = (ch == blocked_byte) ? '0 : m + 1'b1;
			upper_sizes[c[TB_CW-1:0]] = here;
			run_left = here;
			run_diag = up;
			if (here > best_side) begin
				best_side = here;
				best_row_end = cur_row;
				best_col_end = c;
			end
			if (c + 1 >= cols) begin
				cur_col = 0;
				cur_row++;
				run_left = '0;
				run_diag = '0;
			end else begin
				cur_col = c + 1;
			end
		end
		if (lc) begin
			res.found = (best_side != 0);
			res.top_row = '0;
			res.left_col = '0;
			res.side = '0;
			if (res.found) begin
				res.top_row = POS_W'(best_row_end + 1 - best_side);
				res.left_col = POS_W'(best_col_end + 1 - best_side);
				res.side = best_side;
			end
			pending_squares.push_back(res);
			clear_search();
		end
	endfunction

	task automatic compare_result();
		square_t want;
		if (pending_squares.size() == 0) begin
			flag_mismatch("unexpected result beat", 1, 0);
			return;
		end
		want = pending_squares.pop_front();
		if (found !== want.found)
			flag_mismatch("found", int'(found), int'(want.found));
		if (top_row !== want.top_row)
			flag_mismatch("top_row", int'(top_row), int'(want.top_row));
		if (left_col !== want.left_col)
			flag_mismatch("left_col", int'(left_col), int'(want.left_col));
		if (side !== want.side)
			flag_mismatch("side", int'(side), int'(want.side));
	endtask

	// result side: the stall drawn for a beat is held while that beat waits
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			compare_result();
			stall_left = $urandom_range(0, stall_max);
		end else if (out_valid === 1'b1 && stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left != 0);
	end

	task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic lc);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_char <= ch;
		last_cell <= lc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_cell(ch, lc);
	endtask

	// wait for every queued result, then let the last write-back settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_squares.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [CHAR_W-1:0] obst, input logic [COLS_W-1:0] cols);
		cfg_valid <= 1'b1;
		cfg_index <= REG_OBSTACLE;
		// upper bits are ignored by the obstacle register
		cfg_data <= {3'($urandom), obst};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		blocked_byte = obst;
		cfg_index <= REG_GRID_COLS;
		cfg_data <= cols;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		row_width = cols;
		cfg_valid <= 1'b0;
	endtask

	// n cells, a set bit of the mask marks a blocked cell, last beat closes the grid
	task automatic send_grid(input int n, input logic [63:0] mask, input logic [CHAR_W-1:0] open_ch);
		int k;
		for (k = 0; k < n; k++)
			send_cell(mask[k] ? blocked_byte : open_ch, k == n - 1);
	endtask

	function automatic int pick_pace();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 19;
		endcase
	endfunction

	task automatic test_defaults();
		gap_max = 3;
		stall_max = 3;
		send_cell(8'd111, 1'b0);
		send_cell(8'd0, 1'b0);
		send_cell(8'd255, 1'b0);
		send_cell(8'd111, 1'b1);
		// lone blocked cell: nothing found
		send_cell(8'd111, 1'b1);
	endtask

	task automatic test_obstacle_extremes();
		drain();
		configure(8'hff, 11'd4);
		// two 3x3 squares tie, the upper one wins
		send_grid(16, 64'h0000_0000_0000_0888, 8'h00);
		drain();
		configure(8'h00, 11'd5);
		// two 2x2 squares side by side, the left one wins
		send_grid(10, 64'h0000_0000_0000_0084, 8'hff);
		drain();
		configure(8'h00, 11'd3);
		send_grid(6, 64'h0000_0000_0000_003f, 8'h5a);
	endtask

	task automatic test_width_zero();
		drain();
		configure(8'h2a, 11'd0);
		send_grid(5, 64'h0000_0000_0000_0004, 8'h00);
	endtask

	task automatic test_width_clamp();
		int k;
		drain();
		gap_max = 0;
		stall_max = 0;
		configure(8'h55, 11'h7ff);
		// second row starts after 1024 cells, so a 2x2 square sits at the top left
		for (k = 0; k < 1026; k++)
			send_cell((k < 2 || k >= 1023) ? 8'haa : 8'h55, k == 1025);
	endtask

	task automatic test_row_saturation();
		int k;
		drain();
		configure(8'h00, 11'd1);
		// open cells past the row limit must not count
		for (k = 0; k < 1028; k++)
			send_cell((k < 1024) ? 8'h00 : 8'h01, k == 1027);
	endtask

	task automatic test_width_change_mid_row();
		int k;
		drain();
		gap_max = 3;
		stall_max = 3;
		configure(8'h23, 11'd8);
		for (k = 0; k < 21; k++)
			send_cell(8'h20, 1'b0);
		drain();
		// row in progress is already past the new width, so it ends on the next cell
		configure(8'h23, 11'd3);
		for (k = 0; k < 7; k++)
			send_cell((k == 4) ? 8'h23 : 8'h20, k == 6);
	endtask

	task automatic test_back_to_back();
		int k;
		drain();
		configure(8'h10, 11'd4);
		gap_max = 0;
		stall_max = 19;
		for (k = 0; k < 8; k++)
			send_cell((k % 3 == 0) ? 8'h10 : 8'h11, 1'b1);
		send_grid(2, 64'h1, 8'h12);
	endtask

	task automatic test_random_grids(input int target);
		int                sent, w, rows, total, stop_at, kind, pct, k;
		logic [CHAR_W-1:0] obst, ch, ofs;
		sent = 0;
		w = 1;
		obst = 8'h00;
		while (sent < target) begin
			if (sent == 0 || $urandom_range(0, 3) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: obst = 8'h00;
					1: obst = 8'hff;
					default: obst = CHAR_W'($urandom_range(0, 255));
				endcase
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				configure(obst, COLS_W'(w));
			end
			gap_max = pick_pace();
			stall_max = pick_pace();
			rows = $urandom_range(1, 8);
			total = w * rows;
			// mostly whole grids; some cut short, some pure noise
			kind = $urandom_range(0, 9);
			stop_at = (kind == 0) ? $urandom_range(1, total) : total;
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 10;
				2: pct = 30;
				default: pct = 60;
			endcase
			for (k = 1; k <= stop_at; k++) begin
				if (kind == 1) begin
					ch = CHAR_W'($urandom_range(0, 255));
				end else if ($urandom_range(0, 99) < pct) begin
					ch = obst;
				end else begin
					ofs = CHAR_W'($urandom_range(1, 255));
					ch = obst + ofs;
				end
				send_cell(ch, k == stop_at);
				// sender holds off mid-grid until the result side is empty
				if (kind == 2 && k == stop_at / 2)
					drain();
			end
			sent += stop_at;
		end
	endtask

	initial begin
		int waited;
		upper_sizes = '{default: '0};
		clear_search();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_obstacle_extremes();
		test_width_zero();
		test_width_clamp();
		test_row_saturation();
		test_width_change_mid_row();
		test_back_to_back();
		test_random_grids(200);

		in_valid <= 1'b0;
		waited = 0;
		while (pending_squares.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_squares.size() != 0)
			flag_mismatch("results never delivered", 0, pending_squares.size());
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/lesf_pkg.sv
rtl/largest_empty_square_finder.sv
verif/tb.sv
